@@ rtl/segi_pkg.sv @@
package segi_pkg;

  // Default coordinate width (Q12.4)
  localparam int COORD_WIDTH_DEF = 16;

endpackage

@@ rtl/segi_geom.sv @@
module segi_geom #(
  parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [COORD_WIDTH-1:0]   va_x,
  input  logic signed [COORD_WIDTH-1:0]   va_y,
  input  logic signed [COORD_WIDTH-1:0]   vb_x,
  input  logic signed [COORD_WIDTH-1:0]   vb_y,
  input  logic signed [COORD_WIDTH-1:0]   ua_x,
  input  logic signed [COORD_WIDTH-1:0]   ua_y,
  input  logic signed [COORD_WIDTH-1:0]   ub_x,
  input  logic signed [COORD_WIDTH-1:0]   ub_y,
  output logic                            out_valid,
  output logic                            hit,
  output logic signed [2*COORD_WIDTH+2:0] num,
  output logic signed [2*COORD_WIDTH+2:0] den,
  output logic signed [COORD_WIDTH:0]     vdx,
  output logic signed [COORD_WIDTH:0]     vdy,
  output logic signed [COORD_WIDTH-1:0]   vax,
  output logic signed [COORD_WIDTH-1:0]   vay
);
  import segi_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int D = W + 1;
  localparam int P = 2 * D;
  localparam int C = P + 1;

  logic [3:0] vld_r;

  // stage 1: differences
  logic signed [D-1:0] vdx_r, vdy_r, udx_r, udy_r, odx_r, ody_r, wdx_r, wdy_r;
  logic signed [W-1:0] vax1_r, vay1_r;
  // stage 2: products
  logic signed [P-1:0] m_d0_r, m_d1_r, m_c0_r, m_c1_r, m_t0_r, m_t1_r;
  logic signed [P-1:0] m_v0_r, m_v1_r, m_n00_r, m_n01_r, m_n10_r, m_n11_r;
  logic signed [D-1:0] vdx2_r, vdy2_r;
  logic signed [W-1:0] vax2_r, vay2_r;
  // stage 3: sums
  logic signed [C-1:0] d_r, cv_r, tn_r, vdot_r, n0_r, n1_r;
  logic signed [D-1:0] vdx3_r, vdy3_r;
  logic signed [W-1:0] vax3_r, vay3_r;
  // stage 4: decision
  logic                hit_r, hit_nxt;
  logic signed [C-1:0] num_r, num_nxt, den_r, den_nxt;
  logic signed [D-1:0] vdx4_r, vdy4_r;
  logic signed [W-1:0] vax4_r, vay4_r;

  logic signed [C-1:0] dn, tnn, unn;
  logic                coll, n0_in, n1_in, t_in, u_in;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  // stage 1: edge vectors, sign-extended by one bit
  always_ff @(posedge clk) begin
    if (en) begin
      vdx_r  <= {vb_x[W-1], vb_x} - {va_x[W-1], va_x};
      vdy_r  <= {vb_y[W-1], vb_y} - {va_y[W-1], va_y};
      udx_r  <= {ub_x[W-1], ub_x} - {ua_x[W-1], ua_x};
      udy_r  <= {ub_y[W-1], ub_y} - {ua_y[W-1], ua_y};
      odx_r  <= {ua_x[W-1], ua_x} - {va_x[W-1], va_x};
      ody_r  <= {ua_y[W-1], ua_y} - {va_y[W-1], va_y};
      wdx_r  <= {ub_x[W-1], ub_x} - {va_x[W-1], va_x};
      wdy_r  <= {ub_y[W-1], ub_y} - {va_y[W-1], va_y};
      vax1_r <= va_x;
      vay1_r <= va_y;
    end
  end

  // stage 2: all products of the cross and dot terms
  always_ff @(posedge clk) begin
    if (en) begin
      m_d0_r  <= P'(vdx_r) * P'(udy_r);
      m_d1_r  <= P'(vdy_r) * P'(udx_r);
      m_c0_r  <= P'(odx_r) * P'(vdy_r);
      m_c1_r  <= P'(ody_r) * P'(vdx_r);
      m_t0_r  <= P'(odx_r) * P'(udy_r);
      m_t1_r  <= P'(ody_r) * P'(udx_r);
      m_v0_r  <= P'(vdx_r) * P'(vdx_r);
      m_v1_r  <= P'(vdy_r) * P'(vdy_r);
      m_n00_r <= P'(odx_r) * P'(vdx_r);
      m_n01_r <= P'(ody_r) * P'(vdy_r);
      m_n10_r <= P'(wdx_r) * P'(vdx_r);
      m_n11_r <= P'(wdy_r) * P'(vdy_r);
      vdx2_r  <= vdx_r;
      vdy2_r  <= vdy_r;
      vax2_r  <= vax1_r;
      vay2_r  <= vay1_r;
    end
  end

  // stage 3: cross products and dot products
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= C'(m_d0_r) - C'(m_d1_r);
      cv_r   <= C'(m_c0_r) - C'(m_c1_r);
      tn_r   <= C'(m_t0_r) - C'(m_t1_r);
      vdot_r <= C'(m_v0_r) + C'(m_v1_r);
      n0_r   <= C'(m_n00_r) + C'(m_n01_r);
      n1_r   <= C'(m_n10_r) + C'(m_n11_r);
      vdx3_r <= vdx2_r;
      vdy3_r <= vdy2_r;
      vax3_r <= vax2_r;
      vay3_r <= vay2_r;
    end
  end

  // stage 4: normalize signs, range tests, pick numerator and denominator
  always_comb begin
    coll  = (d_r == '0) && (cv_r == '0);
    dn    = d_r[C-1] ? -d_r  : d_r;
    tnn   = d_r[C-1] ? -tn_r : tn_r;
    unn   = d_r[C-1] ? -cv_r : cv_r;
    n0_in = !n0_r[C-1] && (n0_r <= vdot_r);
    n1_in = !n1_r[C-1] && (n1_r <= vdot_r);
    t_in  = !tnn[C-1] && (tnn <= dn);
    u_in  = !unn[C-1] && (unn <= dn);
    if (coll) begin
      hit_nxt = (vdot_r != '0) && (n0_in || n1_in);
      num_nxt = n0_in ? n0_r : n1_r;
      den_nxt = vdot_r;
    end else begin
      hit_nxt = (d_r != '0) && t_in && u_in;
      num_nxt = tnn;
      den_nxt = dn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      vdx4_r <= vdx3_r;
      vdy4_r <= vdy3_r;
      vax4_r <= vax3_r;
      vay4_r <= vay3_r;
    end
  end

  assign out_valid = vld_r[3];
  assign hit       = hit_r;
  assign num       = num_r;
  assign den       = den_r;
  assign vdx       = vdx4_r;
  assign vdy       = vdy4_r;
  assign vax       = vax4_r;
  assign vay       = vay4_r;

endmodule

@@ rtl/segi_div_step.sv @@
module segi_div_step #(
  parameter int REM_W = 35,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [REM_W-1:0] rem_in,
  input  logic [Q_W-1:0]   low_in,
  input  logic [REM_W-1:0] den_in,
  output logic [REM_W-1:0] rem_out,
  output logic [Q_W-1:0]   low_out,
  output logic [REM_W-1:0] den_out
);
  import segi_pkg::*;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             qbit;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   low_r, low_nxt;
  logic [REM_W-1:0] den_r;

  // one restoring division step: shift in next dividend bit, try subtract
  always_comb begin
    trial   = {rem_in, low_in[Q_W-1]};
    diff    = trial - {1'b0, den_in};
    qbit    = (trial >= {1'b0, den_in});
    rem_nxt = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    low_nxt = {low_in[Q_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      den_r <= den_in;
    end
  end

  assign rem_out = rem_r;
  assign low_out = low_r;
  assign den_out = den_r;

endmodule

@@ rtl/segment_segment_intersection_top.sv @@
// Segment/segment intersection, fully pipelined. One segment pair can be
// accepted every cycle while the output is not stalled and yields exactly
// one result: hit in out_tuser and the meeting point in out_tdata (zero
// when there is no hit). At the default width of 16 there are 17 quotient
// stages plus 6 others: four stages form differences, products, cross/dot
// sums and the range decision, one stage scales the parameter numerator,
// then a restoring divider resolves one quotient bit per stage, and an
// output register holds the result. The whole pipeline advances together,
// so a stalled output holds every stage and backpressures the input.
module segment_segment_intersection_top #(
  parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // va_x, va_y, vb_x, vb_y, ua_x, ua_y, ub_x, ub_y
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // point_x, point_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // hit
  output logic [0:0] out_tuser
);
  import segi_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int D     = W + 1;
  localparam int C     = 2 * D + 1;
  localparam int OUT_W = ((2*W+7)/8)*8;

  logic en;

  logic                g_valid, g_hit;
  logic signed [C-1:0] g_num, g_den;
  logic signed [D-1:0] g_vdx, g_vdy;
  logic signed [W-1:0] g_vax, g_vay;

  // scale stage registers
  logic                s_valid_r, s_hit_r, s_negx_r, s_negy_r;
  logic [C+D-1:0]      s_px_r, s_py_r;
  logic [C-1:0]        s_den_r;
  logic signed [W-1:0] s_vax_r, s_vay_r;
  logic [D-1:0]        absx, absy;

  // divider chain
  logic [C-1:0] rx [0:D];
  logic [C-1:0] ry [0:D];
  logic [D-1:0] lx [0:D];
  logic [D-1:0] ly [0:D];
  logic [C-1:0] dx [0:D];
  logic [C-1:0] dy [0:D];
  logic         dv_r   [1:D];
  logic         dhit_r [1:D];
  logic         dnx_r  [1:D];
  logic         dny_r  [1:D];
  logic [W-1:0] dvax_r [1:D];
  logic [W-1:0] dvay_r [1:D];

  // output register
  logic         o_valid_r;
  logic         o_hit_r, o_hit_nxt;
  logic [W-1:0] o_px_r, o_px_nxt, o_py_r, o_py_nxt;

  assign en        = !o_valid_r || out_tready;
  assign in_tready = en;

  segi_geom #(.COORD_WIDTH(W)) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .va_x     (in_tdata[0*W +: W]),
    .va_y     (in_tdata[1*W +: W]),
    .vb_x     (in_tdata[2*W +: W]),
    .vb_y     (in_tdata[3*W +: W]),
    .ua_x     (in_tdata[4*W +: W]),
    .ua_y     (in_tdata[5*W +: W]),
    .ub_x     (in_tdata[6*W +: W]),
    .ub_y     (in_tdata[7*W +: W]),
    .out_valid(g_valid),
    .hit      (g_hit),
    .num      (g_num),
    .den      (g_den),
    .vdx      (g_vdx),
    .vdy      (g_vdy),
    .vax      (g_vax),
    .vay      (g_vay)
  );

  // scale: num * |vd|, sign kept aside
  assign absx = g_vdx[D-1] ? D'(-g_vdx) : D'(g_vdx);
  assign absy = g_vdy[D-1] ? D'(-g_vdy) : D'(g_vdy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_hit_r  <= g_hit;
      s_negx_r <= g_vdx[D-1];
      s_negy_r <= g_vdy[D-1];
      s_px_r   <= (C+D)'($unsigned(g_num)) * (C+D)'(absx);
      s_py_r   <= (C+D)'($unsigned(g_num)) * (C+D)'(absy);
      s_den_r  <= $unsigned(g_den);
      s_vax_r  <= g_vax;
      s_vay_r  <= g_vay;
    end
  end

  // quotient fits D bits, so the top part of the dividend is the start remainder
  assign rx[0] = s_px_r[C+D-1:D];
  assign ry[0] = s_py_r[C+D-1:D];
  assign lx[0] = s_px_r[D-1:0];
  assign ly[0] = s_py_r[D-1:0];
  assign dx[0] = s_den_r;
  assign dy[0] = s_den_r;

  for (genvar k = 0; k < D; k++) begin : g_div
    segi_div_step #(.REM_W(C), .Q_W(D)) u_step_x (
      .clk    (clk),
      .en     (en),
      .rem_in (rx[k]),
      .low_in (lx[k]),
      .den_in (dx[k]),
      .rem_out(rx[k+1]),
      .low_out(lx[k+1]),
      .den_out(dx[k+1])
    );

    segi_div_step #(.REM_W(C), .Q_W(D)) u_step_y (
      .clk    (clk),
      .en     (en),
      .rem_in (ry[k]),
      .low_in (ly[k]),
      .den_in (dy[k]),
      .rem_out(ry[k+1]),
      .low_out(ly[k+1]),
      .den_out(dy[k+1])
    );

    // carry valid and sideband alongside the divider
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[1] <= 1'b0;
        end else if (en) begin
          dv_r[1] <= s_valid_r;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dhit_r[1] <= s_hit_r;
          dnx_r[1]  <= s_negx_r;
          dny_r[1]  <= s_negy_r;
          dvax_r[1] <= s_vax_r;
          dvay_r[1] <= s_vay_r;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[k+1] <= 1'b0;
        end else if (en) begin
          dv_r[k+1] <= dv_r[k];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dhit_r[k+1] <= dhit_r[k];
          dnx_r[k+1]  <= dnx_r[k];
          dny_r[k+1]  <= dny_r[k];
          dvax_r[k+1] <= dvax_r[k];
          dvay_r[k+1] <= dvay_r[k];
        end
      end
    end
  end

  // apply sign, offset from va, zero the point on a miss
  always_comb begin
    o_hit_nxt = dhit_r[D];
    o_px_nxt  = '0;
    o_py_nxt  = '0;
    if (dhit_r[D]) begin
      o_px_nxt = dvax_r[D] + (dnx_r[D] ? -lx[D][W-1:0] : lx[D][W-1:0]);
      o_py_nxt = dvay_r[D] + (dny_r[D] ? -ly[D][W-1:0] : ly[D][W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (en) begin
      o_valid_r <= dv_r[D];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit_r <= o_hit_nxt;
      o_px_r  <= o_px_nxt;
      o_py_r  <= o_py_nxt;
    end
  end

  assign out_tvalid   = o_valid_r;
  assign out_tuser[0] = o_hit_r;
  assign out_tdata    = OUT_W'({o_py_r, o_px_r});

endmodule

@@ rtl/segi_checker.sv @@
module segi_checker #(
  parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [0:0] out_tuser
);
  import segi_pkg::*;

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("miss with nonzero point");

  // input side is ready exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output state");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind segment_segment_intersection_top segi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_segi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
